FILE: src/cau_pkg.sv
// Shared types, widths and helper functions for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // product width, signed sum width, quotient bit count
    localparam int PW = 2 * DATA_WIDTH;
    localparam int MW = PW + 1;
    localparam int QB = DATA_WIDTH + FRAC_BITS + 1;
    // width of the final magnitude before clipping
    localparam int CW = ((MW + 1) > (QB + 1)) ? (MW + 1) : (QB + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // one request in flight through the divider stages
    typedef struct packed {
        op_t            kind;
        logic           dbz;
        logic           nr;
        logic           ni;
        logic [MW-1:0]  mr;
        logic [MW-1:0]  mi;
        logic [PW-1:0]  d;
        logic [PW-1:0]  rr;
        logic [PW-1:0]  ri;
        logic [QB-1:0]  nbr;
        logic [QB-1:0]  nbi;
        logic [QB-1:0]  qr;
        logic [QB-1:0]  qi;
        logic           ovr;
        logic           ovi;
    } stage_t;

    // clip a sign and magnitude to the signed output range; bit DATA_WIDTH is the flag
    function automatic logic [DATA_WIDTH:0] clip_fn(input logic neg, input logic [CW-1:0] mag);
        logic [CW-1:0]         maxpos;
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
        maxpos = CW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
        sat    = 1'b0;
        if (!neg) begin
            if (mag > maxpos) begin
                sat = 1'b1;
                val = maxpos[DATA_WIDTH-1:0];
            end
            else begin
                val = mag[DATA_WIDTH-1:0];
            end
        end
        else begin
            if (mag > maxpos + CW'(1)) begin
                sat = 1'b1;
                val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end
            else begin
                val = DATA_WIDTH'(CW'(0) - mag);
            end
        end
        return {sat, val};
    endfunction

endpackage

FILE: src/cau_front.sv
// Front end: operand products, signed sums, sign and magnitude, divider setup.
// Three register stages. Depends on cau_pkg.
module cau_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  cau_pkg::op_t  kind,
    input  cau_pkg::data_t a_re,
    input  cau_pkg::data_t a_im,
    input  cau_pkg::data_t b_re,
    input  cau_pkg::data_t b_im,
    output logic          out_vld,
    output cau_pkg::stage_t dout
);
    import cau_pkg::*;

    logic v1_reg, v2_reg, v3_reg;

    op_t                      k1_reg, k2_reg;
    logic signed [PW-1:0]     prr_reg, pii_reg, pri_reg, pir_reg, pbb_reg, pcc_reg;
    logic signed [DATA_WIDTH:0] sre_reg, sim_reg;
    logic signed [MW-1:0]     re2_reg, im2_reg;
    logic [PW-1:0]            d2_reg;
    stage_t                   s3_reg;

    logic signed [MW-1:0]     re2_next, im2_next;
    stage_t                   s3_next;
    logic [MW-1:0]            magr, magi, shr, shi;
    logic [MW+FRAC_BITS-1:0]  nfr, nfi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: six products and the add/subtract sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg  <= kind;
            prr_reg <= PW'(a_re) * PW'(b_re);
            pii_reg <= PW'(a_im) * PW'(b_im);
            pri_reg <= PW'(a_re) * PW'(b_im);
            pir_reg <= PW'(a_im) * PW'(b_re);
            pbb_reg <= PW'(b_re) * PW'(b_re);
            pcc_reg <= PW'(b_im) * PW'(b_im);
            if (kind == OP_SUB)
            begin
                sre_reg <= {a_re[DATA_WIDTH-1], a_re} - {b_re[DATA_WIDTH-1], b_re};
                sim_reg <= {a_im[DATA_WIDTH-1], a_im} - {b_im[DATA_WIDTH-1], b_im};
            end
            else
            begin
                sre_reg <= {a_re[DATA_WIDTH-1], a_re} + {b_re[DATA_WIDTH-1], b_re};
                sim_reg <= {a_im[DATA_WIDTH-1], a_im} + {b_im[DATA_WIDTH-1], b_im};
            end
        end
    end

    // stage 2: combine products, divisor magnitude squared
    always_comb
    begin
        case (k1_reg)
            OP_MUL:
            begin
                re2_next = {prr_reg[PW-1], prr_reg} - {pii_reg[PW-1], pii_reg};
                im2_next = {pri_reg[PW-1], pri_reg} + {pir_reg[PW-1], pir_reg};
            end
            OP_DIV:
            begin
                re2_next = {prr_reg[PW-1], prr_reg} + {pii_reg[PW-1], pii_reg};
                im2_next = {pir_reg[PW-1], pir_reg} - {pri_reg[PW-1], pri_reg};
            end
            default:
            begin
                re2_next = MW'(sre_reg);
                im2_next = MW'(sim_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_reg  <= k1_reg;
            re2_reg <= re2_next;
            im2_reg <= im2_next;
            d2_reg  <= PW'(pbb_reg) + PW'(pcc_reg);
        end
    end

    // stage 3: sign and magnitude, seed the long division
    always_comb
    begin
        magr = re2_reg[MW-1] ? MW'(-re2_reg) : MW'(re2_reg);
        magi = im2_reg[MW-1] ? MW'(-im2_reg) : MW'(im2_reg);
        shr  = magr >> (DATA_WIDTH + 1);
        shi  = magi >> (DATA_WIDTH + 1);
        nfr  = (MW+FRAC_BITS)'(magr) << FRAC_BITS;
        nfi  = (MW+FRAC_BITS)'(magi) << FRAC_BITS;

        s3_next.kind = k2_reg;
        s3_next.dbz  = (k2_reg == OP_DIV) && (d2_reg == '0);
        s3_next.nr   = re2_reg[MW-1];
        s3_next.ni   = im2_reg[MW-1];
        s3_next.mr   = magr;
        s3_next.mi   = magi;
        s3_next.d    = d2_reg;
        s3_next.rr   = PW'(shr);
        s3_next.ri   = PW'(shi);
        s3_next.nbr  = nfr[QB-1:0];
        s3_next.nbi  = nfi[QB-1:0];
        s3_next.qr   = '0;
        s3_next.qi   = '0;
        s3_next.ovr  = shr >= MW'(d2_reg);
        s3_next.ovi  = shi >= MW'(d2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_vld = v3_reg;
    assign dout    = s3_reg;

endmodule

FILE: src/cau_div_step.sv
// One restoring division stage: one quotient bit for each part per cycle while en is high.
// Depends on cau_pkg.
module cau_div_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  cau_pkg::stage_t din,
    output logic            out_vld,
    output cau_pkg::stage_t dout
);
    import cau_pkg::*;

    logic   vld_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [PW:0] r2r, r2i, dx;
    logic        ger, gei;

    always_comb
    begin
        dx  = {1'b0, din.d};
        r2r = {din.rr, din.nbr[QB-1]};
        r2i = {din.ri, din.nbi[QB-1]};
        ger = r2r >= dx;
        gei = r2i >= dx;

        data_next     = din;
        data_next.rr  = ger ? PW'(r2r - dx) : PW'(r2r);
        data_next.ri  = gei ? PW'(r2i - dx) : PW'(r2i);
        data_next.nbr = din.nbr << 1;
        data_next.nbi = din.nbi << 1;
        data_next.qr  = {din.qr[QB-2:0], ger};
        data_next.qi  = {din.qi[QB-2:0], gei};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld = vld_reg;
    assign dout    = data_reg;

endmodule

FILE: src/cau_back.sv
// Back end: round, select by operation, saturate, output register.
// Depends on cau_pkg.
module cau_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  cau_pkg::stage_t din,
    output logic            out_vld,
    output cau_pkg::data_t  res_re,
    output cau_pkg::data_t  res_im,
    output logic            saturated,
    output logic            divide_by_zero
);
    import cau_pkg::*;

    localparam logic [CW-1:0] HALF = (FRAC_BITS > 0) ?
        CW'(64'd1 << ((FRAC_BITS > 0) ? (FRAC_BITS - 1) : 0)) : CW'(0);

    logic                  vld_reg;
    data_t                 re_reg, im_reg;
    logic                  sat_reg, dbz_reg;

    logic [CW-1:0]         fmr, fmi;
    logic                  fnr, fni;
    logic [DATA_WIDTH:0]   cr, ci;
    logic [PW:0]           twor, twoi;

    always_comb
    begin
        twor = {din.rr, 1'b0};
        twoi = {din.ri, 1'b0};
        fnr  = din.nr;
        fni  = din.ni;
        case (din.kind)
            OP_MUL:
            begin
                fmr = (CW'(din.mr) + HALF) >> FRAC_BITS;
                fmi = (CW'(din.mi) + HALF) >> FRAC_BITS;
            end
            OP_DIV:
            begin
                if (din.dbz)
                begin
                    fmr = '0;
                    fmi = '0;
                    fnr = 1'b0;
                    fni = 1'b0;
                end
                else
                begin
                    fmr = din.ovr ? '1 :
                          CW'(din.qr) + CW'(twor >= {1'b0, din.d});
                    fmi = din.ovi ? '1 :
                          CW'(din.qi) + CW'(twoi >= {1'b0, din.d});
                end
            end
            default:
            begin
                fmr = CW'(din.mr);
                fmi = CW'(din.mi);
            end
        endcase
        cr = clip_fn(fnr, fmr);
        ci = clip_fn(fni, fmi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg  <= cr[DATA_WIDTH-1:0];
            im_reg  <= ci[DATA_WIDTH-1:0];
            sat_reg <= cr[DATA_WIDTH] | ci[DATA_WIDTH];
            dbz_reg <= din.dbz;
        end
    end

    assign out_vld        = vld_reg;
    assign res_re         = re_reg;
    assign res_im         = im_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dbz_reg;

endmodule

FILE: src/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: add, subtract, multiply, divide.
// Depends on cau_pkg, cau_front, cau_div_step, cau_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | kind, a_re, a_im, b_re, b_im
//  output  | out_valid / out_ready| res_re, res_im, saturated, divide_by_zero
//
// One request enters per cycle while in_ready is high. Data is Q8.8; the pipe is
// three front stages, one stage per quotient bit and one output stage. All
// kinds take the same path, so results leave in request order.
// Reset clears only the valid bits; data registers hold garbage harmlessly.
// A stall freezes every stage at once: when out_valid is high and out_ready
// is low, in_ready drops and nothing advances.
module complex_arithmetic_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  cau_pkg::data_t a_re,
    input  cau_pkg::data_t a_im,
    input  cau_pkg::data_t b_re,
    input  cau_pkg::data_t b_im,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::data_t res_re,
    output cau_pkg::data_t res_im,
    output logic           saturated,
    output logic           divide_by_zero
);
    import cau_pkg::*;

    logic   en;
    logic   vld_chain [QB+1];
    stage_t data_chain [QB+1];

    // advance the whole pipe whenever the output slot is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .kind    (op_t'(kind)),
        .a_re    (a_re),
        .a_im    (a_im),
        .b_re    (b_re),
        .b_im    (b_im),
        .out_vld (vld_chain[0]),
        .dout    (data_chain[0])
    );

    // one quotient bit per stage for both parts
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        cau_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (vld_chain[g]),
            .din     (data_chain[g]),
            .out_vld (vld_chain[g+1]),
            .dout    (data_chain[g+1])
        );
    end

    cau_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_vld         (vld_chain[QB]),
        .din            (data_chain[QB]),
        .out_vld        (out_valid),
        .res_re         (res_re),
        .res_im         (res_im),
        .saturated      (saturated),
        .divide_by_zero (divide_by_zero)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for complex_arithmetic_unit: add, subtract, multiply, divide.
// Depends on cau_pkg and the unit's RTL; predicts each result in-line and compares.
module testbench;
    import cau_pkg::*;

    localparam int LATENCY   = 3 + QB + 1;
    localparam int MAX_CYCLE = 200000;

    // one request and its predicted result
    typedef struct {
        op_t   kind;
        data_t a_re, a_im, b_re, b_im;
    } request_t;

    typedef struct {
        data_t res_re, res_im;
        logic  saturated, divide_by_zero;
    } answer_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    logic [1:0] kind = '0;
    data_t a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    data_t res_re, res_im;
    logic  saturated, divide_by_zero;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int  errors = 0;
    int  cycle = 0;
    int  sent = 0, received = 0;
    bit  stimulus_done = 0;
    bit  calm = 0;          // no idling in the last part of the run
    bit  hold_off = 0;      // long receiver stall in progress
    int  ops_seen[4] = '{0, 0, 0, 0};
    int  sat_seen = 0, dbz_seen = 0;

    complex_arithmetic_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_re(res_re), .res_im(res_im),
        .saturated(saturated), .divide_by_zero(divide_by_zero)
    );

    always #5 clk = ~clk;

    // Clip a signed wide value to the output range; raise sat when clipped.
    function automatic data_t clamp(input longint v, inout logic sat);
        longint hi, lo;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -(64'sd1 <<< (DATA_WIDTH - 1));
        if (v > hi) begin sat = 1'b1; return data_t'(hi); end
        if (v < lo) begin sat = 1'b1; return data_t'(lo); end
        return data_t'(v);
    endfunction

    // Round v / 2^FRAC_BITS to nearest, ties away from zero.
    function automatic longint round_frac(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (FRAC_BITS > 0 ? (64'sd1 <<< (FRAC_BITS - 1)) : 0)) >>> FRAC_BITS;
        return (v < 0) ? -m : m;
    endfunction

    // Round v * 2^FRAC_BITS / d to nearest, ties away from zero, d > 0.
    // Magnitude is capped just above the range so the math stays in 64 bits.
    function automatic longint quotient(input longint v, input longint d);
        longint m, q, r;
        m = (v < 0) ? -v : v;
        q = m / d;
        r = m % d;
        if (q > (64'sd1 <<< DATA_WIDTH))
            q = 64'sd1 <<< DATA_WIDTH;
        else begin
            for (int i = 0; i < FRAC_BITS; i++) begin
                q = q << 1;
                if (r >= d - r) begin q |= 1; r = r - (d - r); end
                else r = r << 1;
            end
            if (r >= d - r) q++;
        end
        return (v < 0) ? -q : q;
    endfunction

    function automatic answer_t complex_result(input request_t t);
        answer_t ans;
        longint ar, ai, br, bi, d, wr, wi;
        logic sat;
        ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
        sat = 1'b0;
        ans.divide_by_zero = 1'b0;
        case (t.kind)
            OP_ADD: begin wr = ar + br; wi = ai + bi; end
            OP_SUB: begin wr = ar - br; wi = ai - bi; end
            OP_MUL: begin
                wr = round_frac(ar * br - ai * bi);
                wi = round_frac(ar * bi + ai * br);
            end
            default: begin
                d = br * br + bi * bi;
                if (d == 0) begin
                    ans.divide_by_zero = 1'b1;
                    wr = 0; wi = 0;
                end
                else begin
                    wr = quotient(ar * br + ai * bi, d);
                    wi = quotient(ai * br - ar * bi, d);
                end
            end
        endcase
        ans.res_re = clamp(wr, sat);
        ans.res_im = clamp(wi, sat);
        ans.saturated = sat;
        return ans;
    endfunction

    function automatic data_t pick_operand();
        case ($urandom_range(0, 9))
            0: return data_t'(16'h7FFF);
            1: return data_t'(16'h8000);
            2: return '0;
            3, 4: return data_t'($signed($urandom_range(0, 1023)) - 512);
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic add_request(input op_t k, input int ar, input int ai,
                               input int br, input int bi);
        request_t t;
        t.kind = k;
        t.a_re = data_t'(ar); t.a_im = data_t'(ai);
        t.b_re = data_t'(br); t.b_im = data_t'(bi);
        pending_requests.push_back(t);
    endtask

    // Fill the request queue: directed corners first, then random mixes.
    initial begin
        add_request(OP_ADD, 32767, -32768, 32767, -32768);
        add_request(OP_ADD, -32768, 32767, 1, -1);
        add_request(OP_ADD, 256, -256, 512, 128);
        add_request(OP_SUB, -32768, 32767, 32767, -32768);
        add_request(OP_SUB, 0, 0, -32768, -32768);
        add_request(OP_SUB, 1000, -1000, 999, -1001);
        add_request(OP_MUL, 256, 0, 256, 0);
        add_request(OP_MUL, 32767, 32767, 32767, 32767);
        add_request(OP_MUL, -32768, -32768, -32768, 32767);
        add_request(OP_MUL, 1, 0, 128, 0);     // tie rounds away from zero
        add_request(OP_MUL, -1, 0, 128, 0);    // negative tie
        add_request(OP_MUL, 3, 5, -7, 11);
        add_request(OP_DIV, 256, 256, 0, 0);   // zero divisor
        add_request(OP_DIV, 32767, -32768, 0, 0);
        add_request(OP_DIV, 256, 0, 256, 0);
        add_request(OP_DIV, 32767, 32767, 1, 0);
        add_request(OP_DIV, -32768, -32768, 0, 1);
        add_request(OP_DIV, 1, 0, 512, 0);     // half step, rounds up
        add_request(OP_DIV, 100, 200, -300, 400);
        add_request(OP_DIV, -32768, 0, -32768, -32768);
        for (int i = 0; i < 500; i++) begin
            request_t t;
            t.kind = op_t'($urandom_range(0, 3));
            t.a_re = pick_operand(); t.a_im = pick_operand();
            t.b_re = pick_operand(); t.b_im = pick_operand();
            if (t.kind == OP_DIV && $urandom_range(0, 15) == 0) begin
                t.b_re = '0; t.b_im = '0;
            end
            pending_requests.push_back(t);
        end
    end

    // Reset once, then let the handshakes run.
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        calm <= (pending_requests.size() < 60);
        if (cycle >= MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: hold valid and payload until accepted, idle in random bursts.
    int send_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            automatic bit taken = in_valid && in_ready;
            if (taken) sent <= sent + 1;
            if (!in_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0) begin
                    request_t t;
                    t = pending_requests.pop_front();
                    expected_answers.push_back(complex_result(t));
                    ops_seen[t.kind]++;
                    in_valid <= 1'b1;
                    kind <= t.kind;
                    a_re <= t.a_re; a_im <= t.a_im;
                    b_re <= t.b_re; b_im <= t.b_im;
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
                else begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Receiver stall: once, early, hold off long enough to fill the pipeline.
    int hold_count = 0;
    bit hold_used = 0;
    always @(posedge clk) begin
        if (rst_n && !hold_used && sent >= 40) begin
            if (hold_count >= 4 * LATENCY) begin
                hold_off <= 1'b0;
                hold_used <= 1'b1;
            end
            else begin
                hold_off <= 1'b1;
                hold_count <= hold_count + 1;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                received <= received + 1;
                if (expected_answers.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (saturated) sat_seen++;
                    if (divide_by_zero) dbz_seen++;
                    if (res_re !== e.res_re) begin
                        $error("res_re: expected %0d, got %0d", e.res_re, res_re);
                        errors++;
                    end
                    if (res_im !== e.res_im) begin
                        $error("res_im: expected %0d, got %0d", e.res_im, res_im);
                        errors++;
                    end
                    if (saturated !== e.saturated) begin
                        $error("saturated: expected %0b, got %0b", e.saturated, saturated);
                        errors++;
                    end
                    if (divide_by_zero !== e.divide_by_zero) begin
                        $error("divide_by_zero: expected %0b, got %0b",
                               e.divide_by_zero, divide_by_zero);
                        errors++;
                    end
                end
            end
            // stall in random bursts unless calm or in the long hold-off
            if (hold_off) out_ready <= 1'b0;
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else out_ready <= 1'b1;
        end
    end

    // End of run: drain, linger for the latency, then report.
    initial begin
        wait (stimulus_done);
        wait (expected_answers.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d results: add %0d, sub %0d, mul %0d, div %0d",
                 received, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
        $display("saturated results %0d, zero-divisor results %0d", sat_seen, dbz_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
